[design/rhc_pkg.sv]
package rhc_pkg;

    localparam int DivNumW         = 18;
    localparam int DivDenW         = 10;
    localparam int DivQW           = 9;
    localparam int DivBitsPerStage = 3;
    localparam int LightNumW       = 14;
    localparam int LightRecip      = 10281;
    localparam int LightShift      = 20;
    localparam int LightProdW      = 28;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix_in;

    typedef struct packed {
        logic [8:0] hue_deg;
        logic [6:0] sat_pct;
        logic [6:0] light_pct;
    } t_pix_out;

    typedef struct packed {
        logic [DivDenW-1:0] rem;
        logic [DivQW-1:0]   sh;
        logic [DivDenW-1:0] den;
    } t_div;

endpackage

[design/rhc_div_step.sv]
module rhc_div_step (
    input  rhc_pkg::t_div i_div,
    output rhc_pkg::t_div o_div
);

    // Each step shifts one dividend bit into the remainder and one quotient bit into sh.
    always_comb begin
        rhc_pkg::t_div              v;
        logic [rhc_pkg::DivDenW:0]  t;
        v = i_div;
        for (int k = 0; k < rhc_pkg::DivBitsPerStage; k++) begin
            t    = {v.rem, v.sh[rhc_pkg::DivQW-1]};
            v.sh = {v.sh[rhc_pkg::DivQW-2:0], 1'b0};
            if (t >= {1'b0, v.den}) begin
                t       = t - {1'b0, v.den};
                v.sh[0] = 1'b1;
            end
            v.rem = t[rhc_pkg::DivDenW-1:0];
        end
        o_div = v;
    end

endmodule

[design/rgb_to_hsl_converter_top.sv]
// Channel   Direction  Handshake          Word
// input     in         i_valid / o_stall  i_data  (red, green, blue)
// output    out        o_valid / i_stall  o_data  (hue_deg, sat_pct, light_pct)
//
// A word is accepted every cycle while o_stall is low; each result passes through registers r_s1 to r_s5.
// The pipeline depth is set by the two nine-bit restoring dividers, three bits per stage.
// Reset is synchronous and active low; it clears only the stage valid bits.
// A stall on the output fills empty stages first and then holds every word in place.
module rgb_to_hsl_converter_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  rhc_pkg::t_pix_in   i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output rhc_pkg::t_pix_out  o_data
);

    typedef enum logic [2:0] {
        SEL_RED   = 3'b001,
        SEL_GREEN = 3'b010,
        SEL_BLUE  = 3'b100
    } t_hue_sel;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] delta;
        logic [8:0] sum;
        t_hue_sel   sel;
    } t_stage1;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;

    t_stage1                          r_s1, n_s1;
    rhc_pkg::t_div                    r_s2_hue, r_s2_sat, n_s2_hue, n_s2_sat;
    logic [rhc_pkg::LightNumW-1:0]    r_s2_light_x, n_s2_light_x;
    rhc_pkg::t_div                    r_s3_hue, r_s3_sat, n_s3_hue, n_s3_sat;
    rhc_pkg::t_div                    r_s4_hue, r_s4_sat, n_s4_hue, n_s4_sat;
    rhc_pkg::t_div                    r_s5_hue, r_s5_sat, n_s5_hue, n_s5_sat;
    logic [6:0]                       r_s3_light, r_s4_light, r_s5_light, n_s3_light;
    logic [rhc_pkg::LightProdW-1:0]   light_prod;

    assign en5     = !r_v5 || !i_stall;
    assign en4     = !r_v4 || en5;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;

    always_comb begin
        logic [7:0] mx, mn;
        mx = i_data.red;
        mn = i_data.red;
        if (i_data.green > mx) mx = i_data.green;
        if (i_data.blue > mx)  mx = i_data.blue;
        if (i_data.green < mn) mn = i_data.green;
        if (i_data.blue < mn)  mn = i_data.blue;
        n_s1.red   = i_data.red;
        n_s1.green = i_data.green;
        n_s1.blue  = i_data.blue;
        n_s1.delta = mx - mn;
        n_s1.sum   = {1'b0, mx} + {1'b0, mn};
        priority if (i_data.red == mx) begin
            n_s1.sel = SEL_RED;
        end else if (i_data.green == mx) begin
            n_s1.sel = SEL_GREEN;
        end else begin
            n_s1.sel = SEL_BLUE;
        end
    end

    always_comb begin
        logic [rhc_pkg::DivNumW-1:0] rx, gx, bx, dx, num, hue_n, sat_n;
        logic [8:0]                  den_s;
        rx    = rhc_pkg::DivNumW'(r_s1.red);
        gx    = rhc_pkg::DivNumW'(r_s1.green);
        bx    = rhc_pkg::DivNumW'(r_s1.blue);
        dx    = rhc_pkg::DivNumW'(r_s1.delta);
        den_s = (r_s1.sum < 9'd255) ? r_s1.sum : 9'(10'd510 - {1'b0, r_s1.sum});
        unique case (r_s1.sel)
            SEL_RED: begin
                if (r_s1.green >= r_s1.blue) begin
                    num = 18'd60 * (gx - bx);
                end else begin
                    num = 18'd360 * dx - 18'd60 * (bx - gx);
                end
            end
            SEL_GREEN: num = 18'd120 * dx + 18'd60 * bx - 18'd60 * rx;
            SEL_BLUE:  num = 18'd240 * dx + 18'd60 * rx - 18'd60 * gx;
            default:   num = '0;
        endcase
        hue_n = {num[rhc_pkg::DivNumW-2:0], 1'b0} + dx;
        sat_n = 18'd200 * dx + rhc_pkg::DivNumW'(den_s);
        if (r_s1.delta == 8'd0) begin
            hue_n        = '0;
            sat_n        = '0;
            n_s2_hue.den = rhc_pkg::DivDenW'(1);
            n_s2_sat.den = rhc_pkg::DivDenW'(1);
        end else begin
            n_s2_hue.den = {1'b0, r_s1.delta, 1'b0};
            n_s2_sat.den = {den_s, 1'b0};
        end
        n_s2_hue.rem = rhc_pkg::DivDenW'(hue_n[rhc_pkg::DivNumW-1:rhc_pkg::DivQW]);
        n_s2_hue.sh  = hue_n[rhc_pkg::DivQW-1:0];
        n_s2_sat.rem = rhc_pkg::DivDenW'(sat_n[rhc_pkg::DivNumW-1:rhc_pkg::DivQW]);
        n_s2_sat.sh  = sat_n[rhc_pkg::DivQW-1:0];
        n_s2_light_x = 14'd20 * rhc_pkg::LightNumW'(r_s1.sum) + 14'd51;
    end

    assign light_prod = rhc_pkg::LightProdW'(r_s2_light_x)
                      * rhc_pkg::LightProdW'(rhc_pkg::LightRecip);
    assign n_s3_light = light_prod[rhc_pkg::LightShift+6:rhc_pkg::LightShift];

    rhc_div_step u_hue_st3 (.i_div(r_s2_hue), .o_div(n_s3_hue));
    rhc_div_step u_sat_st3 (.i_div(r_s2_sat), .o_div(n_s3_sat));
    rhc_div_step u_hue_st4 (.i_div(r_s3_hue), .o_div(n_s4_hue));
    rhc_div_step u_sat_st4 (.i_div(r_s3_sat), .o_div(n_s4_sat));
    rhc_div_step u_hue_st5 (.i_div(r_s4_hue), .o_div(n_s5_hue));
    rhc_div_step u_sat_st5 (.i_div(r_s4_sat), .o_div(n_s5_sat));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1 <= n_s1;
        end
        if (en2) begin
            r_s2_hue     <= n_s2_hue;
            r_s2_sat     <= n_s2_sat;
            r_s2_light_x <= n_s2_light_x;
        end
        if (en3) begin
            r_s3_hue   <= n_s3_hue;
            r_s3_sat   <= n_s3_sat;
            r_s3_light <= n_s3_light;
        end
        if (en4) begin
            r_s4_hue   <= n_s4_hue;
            r_s4_sat   <= n_s4_sat;
            r_s4_light <= r_s3_light;
        end
        if (en5) begin
            r_s5_hue   <= n_s5_hue;
            r_s5_sat   <= n_s5_sat;
            r_s5_light <= r_s4_light;
        end
    end

    assign o_valid          = r_v5;
    assign o_data.hue_deg   = r_s5_hue.sh;
    assign o_data.sat_pct   = r_s5_sat.sh[6:0];
    assign o_data.light_pct = r_s5_light;

    a_div_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_s2_hue.den != '0) && (r_s2_sat.den != '0))
        else $error("divider stage entered with a zero divisor");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r_s3_hue.rem < r_s3_hue.den) && (r_s3_sat.rem < r_s3_sat.den))
        else $error("divider remainder not below divisor");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 |-> (o_data.hue_deg <= 9'd360) && (o_data.sat_pct <= 7'd100)
                 && (o_data.light_pct <= 7'd100))
        else $error("result word out of range");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_v1 && r_v2 && r_v3 && r_v4 && r_v5)
        else $error("input stalled while a pipeline stage is empty");

endmodule
